@@ hdl/amss_pkg.sv @@
// Shared types, constants and tables for the millivolt seven-segment scanner.
// No dependencies.
package amss_pkg;

  localparam int SAMPLE_W = 10;
  localparam int MV_W     = 13;
  localparam int POS_W    = 2;
  localparam int DIGIT_W  = 4;
  localparam int SEG_W    = 7;
  localparam int EN_W     = 4;

  // millivolts = sample * 5000 / 1024 = sample * 625 >> 7
  localparam logic [SAMPLE_W-1:0] MV_SCALE = SAMPLE_W'(625);
  localparam int MV_SHIFT = 7;

  // place divide by reciprocal: q = (mv * recip) >> PLACE_SHIFT, recip rounded up
  localparam int PLACE_SHIFT = 24;
  localparam int RECIP_W     = 21;
  localparam int PLACE_PROD_W = MV_W + RECIP_W;

  // divide by ten for mod 10: t = (q * 6554) >> 16, exact for q < 5000
  localparam logic [MV_W-1:0] DIV10_MUL = MV_W'(6554);
  localparam int DIV10_SHIFT = 16;
  localparam int DIV10_PROD_W = MV_W + MV_W;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [POS_W-1:0] POS_ONES      = 2'd0;
  localparam logic [POS_W-1:0] POS_TENS      = 2'd1;
  localparam logic [POS_W-1:0] POS_HUNDREDS  = 2'd2;
  localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd3;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [POS_W-1:0] pos;
  } amss_entry_t;

  function automatic logic [RECIP_W-1:0] place_recip(input logic [POS_W-1:0] pos);
    logic [RECIP_W-1:0] r;
    unique case (pos)
      POS_TENS:      r = RECIP_W'(1677722);
      POS_HUNDREDS:  r = RECIP_W'(167773);
      POS_THOUSANDS: r = RECIP_W'(16778);
      default:       r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] s;
    unique case (digit)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

@@ hdl/adc_millivolt_seven_segment_scan.sv @@
// Four-digit multiplexed seven-segment voltmeter, top level.
// Depends on amss_pkg, amss_front, amss_queue, amss_back.
//
// Takes one transaction per cycle while s_axis_tready is high. tuser=0 carries a 10-bit ADC
// sample that is scaled to millivolts (sample*5000/1024) and stored; it produces no output.
// tuser=1 is a refresh tick: the digit position advances (mod 4) and one
// output transaction follows with the segment pattern of that decimal digit,
// the decimal point (lit on the thousands digit) and a one-hot digit enable.
// The first tick after reset shows position 1. A tick's job passes through the
// job queue, the stage-1 register and the output register; the queue of
// QUEUE_DEPTH entries lets input keep flowing while the output stalls, and
// s_axis_tready drops only when that queue is full.
module adc_millivolt_seven_segment_scan #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] sample
  input  logic [0:0]  s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [6:0] segments, [7] decimal_point, [11:8] digit_enable
);

  logic                          push;
  amss_pkg::amss_entry_t         push_entry;
  logic                          queue_full;
  logic                          pop;
  amss_pkg::amss_entry_t         pop_entry;
  logic                          queue_not_empty;
  logic                          back_ready;
  logic [amss_pkg::SEG_W-1:0]    segments;
  logic                          decimal_point;
  logic [amss_pkg::EN_W-1:0]     digit_enable;

  amss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .cmd        (s_axis_tuser[0]),
    .sample     (s_axis_tdata[amss_pkg::SAMPLE_W-1:0]),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  amss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .not_empty  (queue_not_empty)
  );

  assign pop = queue_not_empty && back_ready;

  amss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (queue_not_empty),
    .in_ready      (back_ready),
    .in_entry      (pop_entry),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .segments      (segments),
    .decimal_point (decimal_point),
    .digit_enable  (digit_enable)
  );

  assign m_axis_tdata = {4'b0000, digit_enable, decimal_point, segments};

endmodule

@@ hdl/amss_front.sv @@
// Front end: accepts transactions, scales samples to millivolts, advances the
// digit position on ticks and queues display jobs. Depends on amss_pkg.
module amss_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [amss_pkg::SAMPLE_W-1:0]   sample,
  output logic                            push,
  output amss_pkg::amss_entry_t           push_entry,
  input  logic                            queue_full
);

  logic [amss_pkg::MV_W-1:0]              millivolts;
  logic [amss_pkg::POS_W-1:0]             digit_position;
  logic [amss_pkg::POS_W-1:0]             digit_position_next;
  logic [amss_pkg::SAMPLE_W*2-1:0]        scaled;
  logic                                   accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  assign scaled = sample * amss_pkg::MV_SCALE;
  assign digit_position_next = digit_position + 1'b1;

  assign push            = accept && (cmd == amss_pkg::CMD_TICK);
  assign push_entry.mv   = millivolts;
  assign push_entry.pos  = digit_position_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      millivolts     <= '0;
      digit_position <= '0;
    end else if (accept) begin
      if (cmd == amss_pkg::CMD_SAMPLE) begin
        millivolts <= scaled[amss_pkg::MV_SHIFT +: amss_pkg::MV_W];
      end else begin
        digit_position <= digit_position_next;
      end
    end
  end

endmodule

@@ hdl/amss_queue.sv @@
// Small register FIFO of display jobs between front and back end.
// Depends on amss_pkg.
module amss_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  amss_pkg::amss_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output amss_pkg::amss_entry_t pop_entry,
  output logic                  not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  amss_pkg::amss_entry_t store [DEPTH];
  logic [AW-1:0]         wr_ptr;
  logic [AW-1:0]         rd_ptr;
  logic [CW-1:0]         count;
  logic                  do_push;
  logic                  do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_entry = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/amss_back.sv @@
// Back end: picks the decimal digit of the queued value, looks up its segment
// pattern and holds the result in the output register. Depends on amss_pkg.
module amss_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  amss_pkg::amss_entry_t in_entry,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [amss_pkg::SEG_W-1:0] segments,
  output logic                  decimal_point,
  output logic [amss_pkg::EN_W-1:0]  digit_enable
);

  // stage 1: value divided by the place weight
  logic                          s1_valid;
  logic [amss_pkg::MV_W-1:0]     s1_quot;
  logic [amss_pkg::POS_W-1:0]    s1_pos;
  logic                          s1_ready;
  logic                          out_free;

  logic [amss_pkg::PLACE_PROD_W-1:0] place_prod;
  logic [amss_pkg::MV_W-1:0]         quot;

  logic [amss_pkg::DIV10_PROD_W-1:0] div10_prod;
  logic [amss_pkg::MV_W-1:0]         tens;
  logic [amss_pkg::MV_W-1:0]         rem;
  logic [amss_pkg::DIGIT_W-1:0]      digit;

  assign out_free = !out_valid || out_ready;
  assign s1_ready = !s1_valid || out_free;
  assign in_ready = s1_ready;

  assign place_prod = in_entry.mv * amss_pkg::place_recip(in_entry.pos);
  assign quot = (in_entry.pos == amss_pkg::POS_ONES) ? in_entry.mv
              : amss_pkg::MV_W'(place_prod >> amss_pkg::PLACE_SHIFT);

  assign div10_prod = s1_quot * amss_pkg::DIV10_MUL;
  assign tens  = amss_pkg::MV_W'(div10_prod >> amss_pkg::DIV10_SHIFT);
  assign rem   = s1_quot - ((tens << 3) + (tens << 1));
  assign digit = rem[amss_pkg::DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_quot <= quot;
      s1_pos  <= in_entry.pos;
    end
    if (out_free && s1_valid) begin
      segments      <= amss_pkg::seg_pattern(digit);
      decimal_point <= (s1_pos == amss_pkg::POS_THOUSANDS);
      digit_enable  <= amss_pkg::EN_W'(1) << s1_pos;
    end
  end

endmodule
